[rtl/imdtrd_pkg.sv]
// shared types and constants for the track record decoder
// used by imdtrd_parser and imd_track_record_decoder_top, no dependencies
package imdtrd_pkg;

   localparam int MAX_SIZE_CODE_DEF = 6;
   localparam int MAX_SECTORS       = 255;
   localparam int SIZE_BASE_LOG     = 7;
   localparam int TYPE_MAX          = 8;

   typedef enum logic [2:0] {
      KIND_HEADER      = 3'd0,
      KIND_SECTOR_NUM  = 3'd1,
      KIND_CYL_MAP     = 3'd2,
      KIND_HEAD_MAP    = 3'd3,
      KIND_DATA        = 3'd4,
      KIND_FILL        = 3'd5,
      KIND_UNAVAILABLE = 3'd6,
      KIND_ERROR       = 3'd7
   } kind_type;

   localparam logic [7:0] ERR_SIZE      = 8'd0;
   localparam logic [7:0] ERR_TYPE      = 8'd1;
   localparam logic [7:0] ERR_TRUNCATED = 8'd2;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [7:0]  value;
      logic [7:0]  sector_index;
      logic [12:0] byte_index;
      logic [3:0]  sector_type;
      logic        record_end;
   } res_type;

   typedef struct packed {
      logic [7:0] track_mode;
      logic [7:0] cylinder;
      logic [3:0] head;
      logic [3:0] map_flags;
      logic [7:0] sector_total;
      logic [2:0] size_code;
   } hdr_type;

endpackage

[rtl/imdtrd_parser.sv]
// record parser: phase, header registers and counters, one byte per step
// depends on imdtrd_pkg
module imdtrd_parser #(
   parameter int MAX_SIZE_CODE = imdtrd_pkg::MAX_SIZE_CODE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                final_req,
   output imdtrd_pkg::res_type res,
   output imdtrd_pkg::hdr_type hdr
);

   localparam int BC_W = imdtrd_pkg::SIZE_BASE_LOG + MAX_SIZE_CODE;

   typedef enum logic [3:0] {
      PH_HDR0 = 4'd0,
      PH_HDR1 = 4'd1,
      PH_HDR2 = 4'd2,
      PH_HDR3 = 4'd3,
      PH_HDR4 = 4'd4,
      PH_SMAP = 4'd5,
      PH_CMAP = 4'd6,
      PH_HMAP = 4'd7,
      PH_TYPE = 4'd8,
      PH_DATA = 4'd9,
      PH_FILL = 4'd10,
      PH_SKIP = 4'd11
   } phase_type;

   phase_type           phase_ff, phase_in;
   imdtrd_pkg::hdr_type hdr_ff, hdr_in;
   logic [7:0]          sc_ff, sc_in;
   logic [BC_W-1:0]     bc_ff, bc_in;
   logic [3:0]          type_ff, type_in;

   logic                sc_last;
   logic [7:0]          sc_inc;
   logic                blk_last;
   logic [14:0]         size_m1;
   logic [13:0]         bc_wide;
   phase_type           map_next;

   assign sc_inc   = sc_ff + 8'd1;
   assign sc_last  = ({1'b0, sc_ff} + 9'd1) >= {1'b0, hdr_ff.sector_total};
   assign size_m1  = (15'd128 << hdr_ff.size_code) - 15'd1;
   assign blk_last = 15'(bc_ff) == size_m1;
   assign bc_wide  = 14'(bc_ff);

   always_comb begin
      case (phase_ff)
         PH_SMAP: begin
            if (hdr_ff.map_flags[3]) begin
               map_next = PH_CMAP;
            end else if (hdr_ff.map_flags[2]) begin
               map_next = PH_HMAP;
            end else begin
               map_next = PH_TYPE;
            end
         end
         PH_CMAP: map_next = hdr_ff.map_flags[2] ? PH_HMAP : PH_TYPE;
         default: map_next = PH_TYPE;
      endcase
   end

   always_comb begin
      phase_in         = phase_ff;
      hdr_in           = hdr_ff;
      sc_in            = sc_ff;
      bc_in            = bc_ff;
      type_in          = type_ff;
      res              = '0;
      res.kind         = imdtrd_pkg::KIND_ERROR;
      res.value        = imdtrd_pkg::ERR_TRUNCATED;
      res.sector_index = sc_ff;
      case (phase_ff)
         PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3: begin
            case (phase_ff)
               PH_HDR0: begin
                  hdr_in.track_mode = data_byte;
                  phase_in          = PH_HDR1;
               end
               PH_HDR1: begin
                  hdr_in.cylinder = data_byte;
                  phase_in        = PH_HDR2;
               end
               PH_HDR2: begin
                  hdr_in.head      = data_byte[3:0];
                  hdr_in.map_flags = data_byte[7:4];
                  phase_in         = PH_HDR3;
               end
               default: begin
                  hdr_in.sector_total = data_byte;
                  phase_in            = PH_HDR4;
               end
            endcase
            if (final_req) begin
               res.valid = 1'b1;
               phase_in  = PH_HDR0;
            end
         end
         PH_HDR4: begin
            hdr_in.size_code = data_byte[2:0];
            sc_in            = '0;
            bc_in            = '0;
            type_in          = '0;
            res.sector_index = '0;
            res.valid        = 1'b1;
            if (data_byte > 8'(MAX_SIZE_CODE)
                  || hdr_ff.sector_total > 8'(imdtrd_pkg::MAX_SECTORS)) begin
               res.value = imdtrd_pkg::ERR_SIZE;
               phase_in  = final_req ? PH_HDR0 : PH_SKIP;
            end else if (final_req && hdr_ff.sector_total != 8'd0) begin
               phase_in = PH_HDR0;
            end else begin
               res.kind       = imdtrd_pkg::KIND_HEADER;
               res.value      = '0;
               res.record_end = hdr_ff.sector_total == 8'd0;
               phase_in       = res.record_end ? PH_HDR0 : PH_SMAP;
            end
         end
         PH_SMAP, PH_CMAP, PH_HMAP: begin
            res.valid = 1'b1;
            if (final_req) begin
               phase_in = PH_HDR0;
            end else begin
               res.kind  = imdtrd_pkg::kind_type'(3'(phase_ff - 4'd4));
               res.value = data_byte;
               if (sc_last) begin
                  sc_in    = '0;
                  phase_in = map_next;
               end else begin
                  sc_in = sc_inc;
               end
            end
         end
         PH_TYPE: begin
            if (data_byte > 8'(imdtrd_pkg::TYPE_MAX)) begin
               res.valid = 1'b1;
               res.value = imdtrd_pkg::ERR_TYPE;
               phase_in  = final_req ? PH_HDR0 : PH_SKIP;
            end else begin
               type_in = data_byte[3:0];
               if (data_byte == 8'd0) begin
                  res.valid = 1'b1;
                  if (final_req && !sc_last) begin
                     phase_in = PH_HDR0;
                  end else begin
                     res.kind       = imdtrd_pkg::KIND_UNAVAILABLE;
                     res.value      = '0;
                     res.record_end = sc_last;
                     sc_in          = sc_last ? 8'd0 : sc_inc;
                     phase_in       = sc_last ? PH_HDR0 : PH_TYPE;
                  end
               end else if (final_req) begin
                  res.valid = 1'b1;
                  phase_in  = PH_HDR0;
               end else begin
                  bc_in    = '0;
                  phase_in = data_byte[0] ? PH_DATA : PH_FILL;
               end
            end
         end
         PH_DATA: begin
            res.valid = 1'b1;
            bc_in     = blk_last ? '0 : bc_ff + BC_W'(1);
            if (final_req && !(blk_last && sc_last)) begin
               phase_in = PH_HDR0;
            end else begin
               res.kind        = imdtrd_pkg::KIND_DATA;
               res.value       = data_byte;
               res.byte_index  = bc_wide[12:0];
               res.sector_type = type_ff;
               res.record_end  = blk_last && sc_last;
               if (blk_last) begin
                  sc_in    = sc_last ? 8'd0 : sc_inc;
                  phase_in = sc_last ? PH_HDR0 : PH_TYPE;
               end
            end
         end
         PH_FILL: begin
            res.valid = 1'b1;
            if (final_req && !sc_last) begin
               phase_in = PH_HDR0;
            end else begin
               res.kind        = imdtrd_pkg::KIND_FILL;
               res.value       = data_byte;
               res.sector_type = type_ff;
               res.record_end  = sc_last;
               sc_in           = sc_last ? 8'd0 : sc_inc;
               phase_in        = sc_last ? PH_HDR0 : PH_TYPE;
            end
         end
         PH_SKIP: begin
            // drop bytes until the end of the image
            if (final_req) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            phase_in = PH_HDR0;
         end
      endcase
      if (!step) begin
         res.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         hdr_ff   <= '0;
         sc_ff    <= '0;
         bc_ff    <= '0;
         type_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         sc_ff    <= sc_in;
         bc_ff    <= bc_in;
         type_ff  <= type_in;
      end
   end

   assign hdr = hdr_ff;

endmodule

[rtl/imd_track_record_decoder_top.sv]
// Track record stream decoder for sector-dump disk images.
// Bytes of the image enter on the req_ channel one per request, req_tlast
// marking the final byte of the image. Back-to-back track records are parsed:
// five header bytes, sector number map, optional cylinder and head maps, then
// one data record per sector. Each meaningful byte yields one tagged result on
// the rsp_ channel (kind on rsp_tuser, record end on rsp_tlast); header bytes
// other than the fifth and nonzero sector type bytes yield none. On a size, type or
// truncation error an error result is given and bytes are dropped up to and
// including the final byte of the image.
// A request waits in the input register while the parser works on it, and the
// result register captures the result when the request advances. Throughput is
// one byte per cycle while the output is free or rsp_tready is high, set by the
// phase and counter update of the parser. While a result waits on rsp_tready, one
// more request is taken into the input register; after that req_tready drops
// until the result leaves. Synchronous reset empties both registers and returns
// the parser to the first header byte with all header registers and counters
// cleared.
// depends on imdtrd_pkg and imdtrd_parser
module imd_track_record_decoder_top #(
   parameter int MAX_SIZE_CODE = imdtrd_pkg::MAX_SIZE_CODE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // final_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // value, sector_index, byte_index, sector_type, track_mode, cylinder, head,
   // map_flags, sector_total, size_code, zero pad
   output logic [71:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // record_end
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_fin_ff;
   logic                out_valid_ff, out_valid_in;
   imdtrd_pkg::res_type out_ff;
   imdtrd_pkg::res_type res;
   imdtrd_pkg::hdr_type hdr;
   logic                advance;
   logic                req_take;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance ? res.valid : (out_valid_ff && !rsp_tready);

   imdtrd_parser #(
      .MAX_SIZE_CODE (MAX_SIZE_CODE)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .final_req (in_fin_ff),
      .res       (res),
      .hdr       (hdr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_fin_ff  <= req_tlast;
      end
      if (advance && res.valid) begin
         out_ff <= res;
      end
   end

   // parser holds still while a result waits, so its header registers
   // still match the result on display
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.record_end;
   assign rsp_tdata  = {4'd0, hdr.size_code, hdr.sector_total, hdr.map_flags, hdr.head,
                        hdr.cylinder, hdr.track_mode, out_ff.sector_type,
                        out_ff.byte_index, out_ff.sector_index, out_ff.value};

`ifndef ASSERT_OFF
   a_err_no_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == imdtrd_pkg::KIND_ERROR |-> !rsp_tlast)
      else $error("error result flagged as record end");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == imdtrd_pkg::KIND_ERROR |->
         rsp_tdata[7:0] == imdtrd_pkg::ERR_SIZE || rsp_tdata[7:0] == imdtrd_pkg::ERR_TYPE
         || rsp_tdata[7:0] == imdtrd_pkg::ERR_TRUNCATED)
      else $error("unknown error code");

   a_bidx_data_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != imdtrd_pkg::KIND_DATA |-> rsp_tdata[28:16] == 13'd0)
      else $error("byte index set outside data result");

   a_hdr_sidx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == imdtrd_pkg::KIND_HEADER |-> rsp_tdata[15:8] == 8'd0)
      else $error("header result with nonzero sector index");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_fin_ff))
      else $error("input register lost a pending request");
`endif

endmodule
